@@ rtl/core/dfmt_pkg.sv @@
// ----------------------------------------------------------------------------
// dfmt_pkg
// Shared types and constants for the decimal ASCII formatter.
// ----------------------------------------------------------------------------
package dfmt_pkg;

  localparam int unsigned CharWidth  = 6;
  localparam int unsigned CountWidth = 4;

  typedef logic [3:0] bcd_digit_t;

  localparam logic [CharWidth-1:0] CHAR_ZERO = 6'd48;
  localparam bcd_digit_t BCD_FIVE  = 4'd5;
  localparam bcd_digit_t BCD_THREE = 4'd3;

endpackage

@@ rtl/core/decimal_ascii_formatter.sv @@
// ----------------------------------------------------------------------------
// decimal_ascii_formatter
// Unsigned binary to decimal ASCII text, most significant digit first.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one value_i per item.
// Output channel: out_valid_o / out_stall_i carry one character per item,
// with last_o on the final digit and digit_count_o on every digit of a run.
// Leading zeros are dropped; zero gives the single character '0'.
// Steps per value:
//   bit-serial double dabble (shift-add-3) over all VALUE_WIDTH bits,
//   then leading zeros are dropped one digit at a time,
//   then one digit per cycle into the output register while the
//   receiver does not stall.
// A new value is taken only after the last digit of the current one
// has entered the output register.
// The next value is accepted while the last digit still waits at the output.
// A stall on the output freezes the current digit and the digit shifter.
// Reset (rst_ni low, asynchronous) returns to idle and drops the output.
// Digit count wraps modulo 16 when VALUE_WIDTH is raised to 50 or more.
// ----------------------------------------------------------------------------
module decimal_ascii_formatter #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [VALUE_WIDTH-1:0]              value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [dfmt_pkg::CharWidth-1:0]      character_o,
  output logic                                last_o,
  output logic [dfmt_pkg::CountWidth-1:0]     digit_count_o
);
  import dfmt_pkg::*;

  localparam int unsigned NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned CW   = $clog2(NDIG + 1);
  localparam int unsigned BW   = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_e;

  state_e                   state_q;
  logic [VALUE_WIDTH-1:0]   val_q;
  logic [BW-1:0]            bits_q;
  bcd_digit_t               bcd_q [NDIG];
  bcd_digit_t               dab_d [NDIG];
  bcd_digit_t               sft_d [NDIG];
  logic [CW-1:0]            cnt_q;
  logic [CW-1:0]            rem_q;
  logic                     out_valid_q;
  logic [CharWidth-1:0]     char_q;
  logic                     last_q;
  logic [CountWidth-1:0]    dcnt_q;
  logic                     slot_free;

  // add-3 correction and one-bit shift through all digits
  always_comb begin
    bcd_digit_t adj [NDIG];
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = (bcd_q[i] >= BCD_FIVE) ? bcd_q[i] + BCD_THREE : bcd_q[i];
    end
    dab_d[0] = {adj[0][2:0], val_q[VALUE_WIDTH-1]};
    for (int i = 1; i < NDIG; i++) begin
      dab_d[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  // one-digit shift toward the top
  always_comb begin
    sft_d[0] = '0;
    for (int i = 1; i < NDIG; i++) begin
      sft_d[i] = bcd_q[i-1];
    end
  end

  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      val_q       <= '0;
      bits_q      <= '0;
      for (int i = 0; i < NDIG; i++) begin
        bcd_q[i] <= '0;
      end
      cnt_q       <= '0;
      rem_q       <= '0;
      char_q      <= '0;
      last_q      <= 1'b0;
      dcnt_q      <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            val_q  <= value_i;
            bits_q <= BW'(VALUE_WIDTH);
            cnt_q  <= CW'(NDIG);
            for (int i = 0; i < NDIG; i++) begin
              bcd_q[i] <= '0;
            end
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd_q  <= dab_d;
          val_q  <= val_q << 1;
          bits_q <= bits_q - BW'(1);
          if (bits_q == BW'(1)) begin
            state_q <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (cnt_q > CW'(1) && bcd_q[NDIG-1] == '0) begin
            bcd_q <= sft_d;
            cnt_q <= cnt_q - CW'(1);
          end else begin
            rem_q   <= cnt_q;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            char_q      <= CHAR_ZERO + CharWidth'(bcd_q[NDIG-1]);
            last_q      <= (rem_q == CW'(1));
            dcnt_q      <= CountWidth'(cnt_q);
            bcd_q       <= sft_d;
            rem_q       <= rem_q - CW'(1);
            if (rem_q == CW'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign character_o   = char_q;
  assign last_o        = last_q;
  assign digit_count_o = dcnt_q;

`ifndef NO_ASSERTIONS
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o >= CHAR_ZERO && character_o <= CHAR_ZERO + 6'd9))
    else $error("character out of digit range");

  a_accept_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_CONV))
    else $error("accepted item did not start conversion");

  a_mid_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (state_q == ST_EMIT))
    else $error("run interrupted before last digit");

  a_next_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o && !out_stall_i) |=> out_valid_o)
    else $error("gap inside a digit run");
`endif

endmodule
